@@ hdl/rcoc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the remote command override controller.
// Holds constants, the command and result types and the pedal scaling function.
// No dependencies.
package rcoc_pkg;

    localparam int LINE_BUFFER = 32;
    localparam int LEN_W       = $clog2(LINE_BUFFER);
    localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(LINE_BUFFER - 1);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [6:0]  PCT_MAX         = 7'd100;
    localparam logic [6:0]  THRESHOLD_RESET = 7'd6;
    localparam logic [15:0] FULL_BRAKE_RESET = 16'd4500;
    localparam logic [12:0] ADC_FULL        = 13'd4095;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [0:0] REG_THRESHOLD  = 1'b0;
    localparam logic [0:0] REG_FULL_BRAKE = 1'b1;

    typedef struct packed {
        logic       thr_set;
        logic [6:0] thr_val;
        logic       brk_set;
        logic       brk_on;
    } cmd_t;

    typedef struct packed {
        logic        remote_mode;
        logic [15:0] brake_level;
        logic [6:0]  throttle_level;
    } result_t;

    // adc * 100 / 4095, rounded down; 4095 = 4096 - 1 so one correction step suffices
    function automatic logic [6:0] pedal_pct(input logic [11:0] adc);
        logic [18:0] prod;
        logic [6:0]  q0;
        logic [12:0] r0;
        logic [6:0]  q;
        prod = 19'(adc) * 19'd100;
        q0   = prod[18:12];
        r0   = {1'b0, prod[11:0]} + 13'(q0);
        q    = (r0 >= ADC_FULL) ? q0 + 7'd1 : q0;
        return q;
    endfunction

endpackage

@@ hdl/rcoc_line_parser.sv @@
`timescale 1ns / 1ps
// Line assembly and command decode for received serial bytes.
// Depends on rcoc_pkg.
module rcoc_line_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_en,
    input  logic [7:0]            rx_byte,
    output rcoc_pkg::cmd_t        cmd
);

    logic [rcoc_pkg::LEN_W-1:0] line_len_reg, line_len_next;
    logic [7:0]                 first_char_reg, first_char_next;
    logic [7:0]                 second_char_reg, second_char_next;
    logic [31:0]                value_accum_reg, value_accum_next;
    logic                       digits_open_reg, digits_open_next;
    logic                       is_digit;
    logic                       cmd_line;
    logic [31:0]                accum_step;

    assign is_digit   = (rx_byte >= rcoc_pkg::CHAR_ZERO) && (rx_byte <= rcoc_pkg::CHAR_NINE);
    assign accum_step = (value_accum_reg << 3) + (value_accum_reg << 1)
                        + 32'(rx_byte - rcoc_pkg::CHAR_ZERO);
    assign cmd_line   = (line_len_reg >= rcoc_pkg::LEN_W'(2))
                        && (second_char_reg == rcoc_pkg::CHAR_COLON);

    always_comb
    begin
        line_len_next    = line_len_reg;
        first_char_next  = first_char_reg;
        second_char_next = second_char_reg;
        value_accum_next = value_accum_reg;
        digits_open_next = digits_open_reg;
        cmd              = '0;
        cmd.thr_val      = (value_accum_reg > 32'(rcoc_pkg::PCT_MAX))
                           ? rcoc_pkg::PCT_MAX : value_accum_reg[6:0];
        cmd.brk_on       = (value_accum_reg == 32'd1);
        if (byte_en && (rx_byte != rcoc_pkg::CHAR_CR))
        begin
            if ((rx_byte == rcoc_pkg::CHAR_LF) || (line_len_reg >= rcoc_pkg::LINE_MAX))
            begin
                if (rx_byte == rcoc_pkg::CHAR_LF && cmd_line)
                begin
                    cmd.thr_set = (first_char_reg == rcoc_pkg::CHAR_A);
                    cmd.brk_set = (first_char_reg == rcoc_pkg::CHAR_B);
                end
                line_len_next    = '0;
                first_char_next  = '0;
                second_char_next = '0;
                value_accum_next = '0;
                digits_open_next = 1'b1;
            end
            else
            begin
                if (line_len_reg == '0)
                begin
                    first_char_next = rx_byte;
                end
                else if (line_len_reg == rcoc_pkg::LEN_W'(1))
                begin
                    second_char_next = rx_byte;
                end
                else if (digits_open_reg)
                begin
                    if (is_digit)
                    begin
                        value_accum_next = accum_step;
                    end
                    else
                    begin
                        digits_open_next = 1'b0;
                    end
                end
                line_len_next = line_len_reg + rcoc_pkg::LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg    <= '0;
            first_char_reg  <= '0;
            second_char_reg <= '0;
            value_accum_reg <= '0;
            digits_open_reg <= 1'b1;
        end
        else
        begin
            line_len_reg    <= line_len_next;
            first_char_reg  <= first_char_next;
            second_char_reg <= second_char_next;
            value_accum_reg <= value_accum_next;
            digits_open_reg <= digits_open_next;
        end
    end

endmodule

@@ hdl/rcoc_drive_ctrl.sv @@
`timescale 1ns / 1ps
// Mode control and throttle/brake arbitration for ticks and decoded commands.
// Depends on rcoc_pkg.
module rcoc_drive_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_en,
    input  logic [11:0]           adc_sample,
    input  logic                  brake_pressed,
    input  rcoc_pkg::cmd_t        cmd,
    input  logic [6:0]            threshold,
    input  logic [15:0]           full_brake,
    output rcoc_pkg::result_t     result
);

    logic       mode_reg, mode_next;
    logic [6:0] pedal_reg, pedal_next;
    logic [6:0] locked_reg, locked_next;
    logic [6:0] rthr_reg, rthr_next;
    logic       rbrk_reg, rbrk_next;
    logic [6:0] pct;
    logic [6:0] delta;
    logic       mode_tick;

    assign pct       = rcoc_pkg::pedal_pct(adc_sample);
    assign delta     = (pct >= locked_reg) ? pct - locked_reg : locked_reg - pct;
    assign mode_tick = mode_reg && !(delta > threshold) && !brake_pressed;

    always_comb
    begin
        mode_next   = mode_reg;
        pedal_next  = pedal_reg;
        locked_next = locked_reg;
        rthr_next   = rthr_reg;
        rbrk_next   = rbrk_reg;
        if (tick_en)
        begin
            pedal_next = pct;
            mode_next  = mode_tick;
        end
        else if (cmd.thr_set || cmd.brk_set)
        begin
            if (!mode_reg)
            begin
                locked_next = pedal_reg;
            end
            mode_next = 1'b1;
            if (cmd.thr_set)
            begin
                rthr_next = cmd.thr_val;
            end
            if (cmd.brk_set)
            begin
                rbrk_next = cmd.brk_on;
            end
        end
    end

    always_comb
    begin
        result.remote_mode = mode_tick;
        priority if (brake_pressed)
        begin
            result.throttle_level = '0;
            result.brake_level    = full_brake;
        end
        else if (!mode_tick)
        begin
            result.throttle_level = pct;
            result.brake_level    = '0;
        end
        else
        begin
            result.throttle_level = rthr_reg;
            result.brake_level    = rbrk_reg ? full_brake : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            pedal_reg  <= '0;
            locked_reg <= '0;
            rthr_reg   <= '0;
            rbrk_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pedal_reg  <= pedal_next;
            locked_reg <= locked_next;
            rthr_reg   <= rthr_next;
            rbrk_reg   <= rbrk_next;
        end
    end

endmodule

@@ hdl/remote_command_override_controller_core.sv @@
`timescale 1ns / 1ps
// Top level of the remote command override controller: stream ports, APB registers,
// input and result registers. Depends on rcoc_pkg, rcoc_line_parser, rcoc_drive_ctrl.
//
// Usage:
//   Input stream (s_*): one item per handshake. s_tuser selects the kind:
//   0 = serial byte in s_tdata[7:0], 1 = control tick with the ADC sample in
//   s_tdata[19:8] and the brake button in s_tdata[20].
//   Output stream (m_*): one item per tick, none per byte, carrying
//   throttle percent, brake torque and the mode after the tick.
//   APB port: register 0 at address 0 is the override threshold (7 bits),
//   register 1 at address 4 is the full brake torque (16 bits). Write only
//   while the block is idle.
//   A tick is registered in the input register, then in the result register that drives m_*.
//   Throughput: one item per cycle, bytes and ticks alike, while a stall on m_* holds
//   no tick back; the input register and the result register hold one item each.
//   Reset: manual mode, line buffer empty, registers at 6 and 4500, no output.
//   Stall: while m_tready is low the result is held; a following byte still
//   passes, a following tick waits in the input register and s_tready drops.
module remote_command_override_controller_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte[7:0], adc_sample[19:8], brake_pressed[20], zero
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // throttle_level[6:0], brake_level[22:7], remote_mode[23]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              in_valid_reg, in_valid_next;
    logic              in_func_reg;
    logic [7:0]        in_byte_reg;
    logic [11:0]       in_adc_reg;
    logic              in_brake_reg;
    logic              out_valid_reg, out_valid_next;
    rcoc_pkg::result_t out_data_reg;
    logic [6:0]        threshold_reg;
    logic [15:0]       full_brake_reg;
    logic              s_accept;
    logic              out_free;
    logic              advance;
    logic              cfg_write;
    rcoc_pkg::cmd_t    cmd;
    rcoc_pkg::result_t result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && ((in_func_reg == rcoc_pkg::FUNC_BYTE) || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        unique case (paddr[2])
            rcoc_pkg::REG_THRESHOLD:  prdata = {25'd0, threshold_reg};
            rcoc_pkg::REG_FULL_BRAKE: prdata = {16'd0, full_brake_reg};
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && (in_func_reg == rcoc_pkg::FUNC_TICK))
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    rcoc_line_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (advance && (in_func_reg == rcoc_pkg::FUNC_BYTE)),
        .rx_byte (in_byte_reg),
        .cmd     (cmd)
    );

    rcoc_drive_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (advance && (in_func_reg == rcoc_pkg::FUNC_TICK)),
        .adc_sample    (in_adc_reg),
        .brake_pressed (in_brake_reg),
        .cmd           (cmd),
        .threshold     (threshold_reg),
        .full_brake    (full_brake_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            threshold_reg  <= rcoc_pkg::THRESHOLD_RESET;
            full_brake_reg <= rcoc_pkg::FULL_BRAKE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (paddr[2])
                    rcoc_pkg::REG_THRESHOLD:  threshold_reg  <= pwdata[6:0];
                    rcoc_pkg::REG_FULL_BRAKE: full_brake_reg <= pwdata[15:0];
                    default:                  threshold_reg  <= threshold_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg  <= s_tuser;
            in_byte_reg  <= s_tdata[7:0];
            in_adc_reg   <= s_tdata[19:8];
            in_brake_reg <= s_tdata[20];
        end
        if (advance && (in_func_reg == rcoc_pkg::FUNC_TICK))
        begin
            out_data_reg <= result;
        end
    end

endmodule

@@ hdl/rcoc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the remote command override controller, with its bind.
// Depends on remote_command_override_controller_core ports only.
module rcoc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    ap_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    ap_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    ap_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] <= 7'd100))
        else $error("throttle above 100 percent");

    ap_manual_brake: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[23] && (m_tdata[22:7] != 16'd0) |-> (m_tdata[6:0] == 7'd0))
        else $error("manual brake with nonzero throttle");

endmodule

bind remote_command_override_controller_core rcoc_checker u_rcoc_checker (.*);
